>>> design/lbp_pkg.sv
package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int CX_W       = 7;
    localparam int CY_W       = 12;
    localparam int ROW_W      = 13;
    localparam int RAD_W      = 2;
    localparam int PTS_W      = 4;
    localparam int IMW_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_LVL_W    = 3;
    localparam int WGT_W      = 16;
    localparam int PROD_W     = 26;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    // one coded center: pixels picked from the window
    typedef struct packed {
        logic [PIX_W-1:0]           center;
        logic [3:0][PIX_W-1:0]      axis;    // right, up, left, down
        logic [3:0][PIX_W-1:0]      outer;   // diagonals d1, d3, d5, d7
        logic [3:0][PIX_W-1:0]      inner;
        logic [3:0][PIX_W:0]        mixed;   // sum of the two cross corners
        logic [CX_W-1:0]            cx;
        logic [CY_W-1:0]            cy;
        logic                       last;
    } t_req;

    typedef struct packed {
        logic [Q_LVL_W-1:0] level;
        logic               empty;
    } t_q_status;

    typedef struct packed {
        logic [WGT_W-1:0] w_oo;
        logic [WGT_W-1:0] w_ii;
        logic [WGT_W-1:0] w_mix;
    } t_wgt;

    // diagonal offset R*0.7071 = k + a/256; outer corner weight a, inner 256-a per axis
    function automatic t_wgt radius_weights(input logic [RAD_W-1:0] rad);
        t_wgt w;
        case (rad)
            2'd2: begin
                w.w_oo  = 16'd11236;
                w.w_ii  = 16'd22500;
                w.w_mix = 16'd15900;
            end
            2'd3: begin
                w.w_oo  = 16'd961;
                w.w_ii  = 16'd50625;
                w.w_mix = 16'd6975;
            end
            default: begin
                w.w_oo  = 16'd32761;
                w.w_ii  = 16'd5625;
                w.w_mix = 16'd13575;
            end
        endcase
        return w;
    endfunction

endpackage

>>> design/circular_lbp_operator.sv
// channel  | handshake         | payload
// ---------+-------------------+-----------------------------------------------
// pixel in | i_valid / o_stall | i_pixel
// code out | o_valid / i_stall | o_lbp_code, o_center_x, o_center_y, o_frame_last
// config   | i_cfg_we          | i_cfg_index, i_cfg_data
//
// One pixel per clock while o_stall is low; a code leaves after its last pixel through
// the bank read, window shift, queue, product lane and compare registers in turn.
// Line banks are 2*MAX_RADIUS+1 RAMs of MAX_WIDTH, read at the incoming column.
// Reset is synchronous; line contents are not cleared, counters are.
// A stalled output backs up a 4-entry request queue; o_stall rises once queued plus in-flight requests fill it.
module circular_lbp_operator #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_RADIUS = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [lbp_pkg::PIX_W-1:0]         i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [lbp_pkg::CODE_W-1:0]        o_lbp_code,
    output logic [lbp_pkg::CX_W-1:0]          o_center_x,
    output logic [lbp_pkg::CY_W-1:0]          o_center_y,
    output logic                              o_frame_last,
    input  logic                              i_cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lbp_pkg::*;

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W = (WW > IMW_W) ? WW : IMW_W;

    logic [RAD_W-1:0]  r_radius;
    logic [PTS_W-1:0]  r_points;
    logic [IMW_W-1:0]  r_width;
    logic [ROW_W-1:0]  r_height;

    logic [RAD_W-1:0]  rad_eff;
    logic [WW-1:0]     width_eff;
    logic [ROW_W-1:0]  height_eff;
    logic              four;

    t_q_status         q_status;
    t_req              push_req, pop_req;
    logic              push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(1);
            r_points <= PTS_W'(8);
            r_width  <= IMW_W'(128);
            r_height <= ROW_W'(128);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                REG_POINTS: r_points <= i_cfg_data[PTS_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_data[IMW_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_radius == '0) begin
            rad_eff = RAD_W'(1);
        end else if (r_radius > RAD_W'(MAX_RADIUS)) begin
            rad_eff = RAD_W'(MAX_RADIUS);
        end else begin
            rad_eff = r_radius;
        end
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (WCMP_W'(r_width) > WCMP_W'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
        height_eff = (r_height == '0) ? ROW_W'(1) : r_height;
        four       = (r_points == PTS_W'(4));
    end

    lbp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_pixel    (i_pixel),
        .o_stall    (o_stall),
        .i_rad      (rad_eff),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .i_q_status (q_status),
        .o_push     (push),
        .o_req      (push_req)
    );

    lbp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_req    (push_req),
        .i_pop    (pop),
        .o_req    (pop_req),
        .o_status (q_status)
    );

    lbp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rad        (rad_eff),
        .i_four       (four),
        .i_q_status   (q_status),
        .i_req        (pop_req),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_lbp_code   (o_lbp_code),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_frame_last (o_frame_last)
    );

endmodule

>>> design/lbp_ram.sv
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lbp_front.sv
module lbp_front #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_RADIUS = 3,
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [lbp_pkg::PIX_W-1:0]        i_pixel,
    output logic                             o_stall,
    input  logic [lbp_pkg::RAD_W-1:0]        i_rad,
    input  logic [WW-1:0]                    i_width,
    input  logic [lbp_pkg::ROW_W-1:0]        i_height,
    input  lbp_pkg::t_q_status               i_q_status,
    output logic                             o_push,
    output lbp_pkg::t_req                    o_req
);
    import lbp_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int NW = 2 * MAX_RADIUS + 1;
    localparam int BW = $clog2(NW);
    localparam int IW = $clog2(NW);

    logic [XW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [BW-1:0]    r_bank, n_bank;

    logic              r_p1_valid, r_p1_emit, r_p1_last;
    logic [PIX_W-1:0]  r_p1_pix;
    logic [BW-1:0]     r_p1_bank;
    logic [CX_W-1:0]   r_p1_cx;
    logic [CY_W-1:0]   r_p1_cy;
    logic              r_p2_valid, r_p2_last;
    logic [CX_W-1:0]   r_p2_cx;
    logic [CY_W-1:0]   r_p2_cy;

    logic [PIX_W-1:0]  r_win [NW][NW];   // [column age][row age]
    logic [PIX_W-1:0]  ram_rdata [NW];
    logic [PIX_W-1:0]  col [NW];

    logic              acc, emit, last, row_end;
    logic [WW-1:0]     col_ext, col_inc;
    logic [ROW_W-1:0]  two_r_row;
    logic [WW-1:0]     two_r_col;
    logic [BW-1:0]     nbanks;
    logic [Q_LVL_W:0]  credit;

    assign two_r_col = WW'({i_rad, 1'b0});
    assign two_r_row = ROW_W'({i_rad, 1'b0});
    assign nbanks    = BW'({i_rad, 1'b0}) + BW'(1);
    assign col_ext   = WW'(r_col);
    assign col_inc   = col_ext + WW'(1);

    assign credit  = (Q_LVL_W + 1)'(i_q_status.level) + (Q_LVL_W + 1)'(r_p1_valid & r_p1_emit)
                   + (Q_LVL_W + 1)'(r_p2_valid);
    assign o_stall = credit >= (Q_LVL_W + 1)'(Q_DEPTH);
    assign acc     = i_valid & ~o_stall;

    assign emit    = (col_ext < i_width) && (r_row < i_height)
                   && (col_ext >= two_r_col) && (r_row >= two_r_row);
    assign last    = (col_inc == i_width)
                   && ({1'b0, r_row} + (ROW_W + 1)'(1) == {1'b0, i_height});
    assign row_end = col_inc >= i_width;

    always_comb begin
        n_col  = r_col + XW'(1);
        n_row  = r_row;
        n_bank = r_bank;
        if (row_end) begin
            n_col = '0;
            if ({1'b0, r_row} + (ROW_W + 1)'(1) >= {1'b0, i_height}) begin
                n_row  = '0;
                n_bank = '0;
            end else begin
                n_row = r_row + ROW_W'(1);
                if ((BW + 1)'(r_bank) + (BW + 1)'(1) >= (BW + 1)'(nbanks)) begin
                    n_bank = '0;
                end else begin
                    n_bank = r_bank + BW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_bank     <= '0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_bank <= n_bank;
            end
            r_p1_valid <= acc;
            r_p2_valid <= r_p1_valid & r_p1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p1_emit <= emit;
            r_p1_last <= last;
            r_p1_pix  <= i_pixel;
            r_p1_bank <= r_bank;
            r_p1_cx   <= CX_W'(r_col - XW'(i_rad));
            r_p1_cy   <= CY_W'(r_row - ROW_W'(i_rad));
        end
        if (r_p1_valid) begin
            r_p2_cx   <= r_p1_cx;
            r_p2_cy   <= r_p1_cy;
            r_p2_last <= r_p1_last;
        end
    end

    // one line bank per stored row, all read at the incoming column
    for (genvar b = 0; b < NW; b++) begin : g_bank
        lbp_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (acc && (r_bank == BW'(b))),
            .i_waddr (r_col),
            .i_wdata (i_pixel),
            .i_re    (acc),
            .i_raddr (r_col),
            .o_rdata (ram_rdata[b])
        );
    end

    // row r-k lives in bank (bank - k) mod (2R+1)
    always_comb begin
        logic [BW:0] idx;
        col[0] = r_p1_pix;
        for (int k = 1; k < NW; k++) begin
            if ((BW + 1)'(r_p1_bank) >= (BW + 1)'(k)) begin
                idx = (BW + 1)'(r_p1_bank) - (BW + 1)'(k);
            end else begin
                idx = (BW + 1)'(r_p1_bank) + (BW + 1)'(nbanks) - (BW + 1)'(k);
            end
            if (idx < (BW + 1)'(NW)) begin
                col[k] = ram_rdata[idx[BW-1:0]];
            end else begin
                col[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            for (int j = NW - 1; j > 0; j--) begin
                r_win[j] <= r_win[j-1];
            end
            for (int k = 0; k < NW; k++) begin
                r_win[0][k] <= col[k];
            end
        end
    end

    // center sits at column age R, row age R
    always_comb begin
        logic [IW-1:0] rr, r2, jo, ji, ko, ki;
        logic          xpos, yup;
        rr = IW'(i_rad);
        r2 = IW'({i_rad, 1'b0});
        o_req.center  = r_win[rr][rr];
        o_req.axis[0] = r_win[0][rr];
        o_req.axis[1] = r_win[rr][r2];
        o_req.axis[2] = r_win[r2][rr];
        o_req.axis[3] = r_win[rr][0];
        for (int i = 0; i < 4; i++) begin
            xpos = (i == 0) || (i == 3);
            yup  = (i == 0) || (i == 1);
            jo   = xpos ? IW'(0) : r2;
            ji   = xpos ? IW'(1) : r2 - IW'(1);
            ko   = yup ? r2 : IW'(0);
            ki   = yup ? r2 - IW'(1) : IW'(1);
            o_req.outer[i] = r_win[jo][ko];
            o_req.inner[i] = r_win[ji][ki];
            o_req.mixed[i] = {1'b0, r_win[jo][ki]} + {1'b0, r_win[ji][ko]};
        end
        o_req.cx   = r_p2_cx;
        o_req.cy   = r_p2_cy;
        o_req.last = r_p2_last;
    end

    assign o_push = r_p2_valid;

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && row_end |=> r_col == '0)
        else $error("column count did not restart at row end");

endmodule

>>> design/lbp_queue.sv
module lbp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lbp_pkg::t_req       i_req,
    input  logic                i_pop,
    output lbp_pkg::t_req       o_req,
    output lbp_pkg::t_q_status  o_status
);
    import lbp_pkg::*;

    t_req                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, r_rd;
    logic [Q_LVL_W-1:0]  r_level;
    logic                do_pop;

    assign do_pop = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_level <= r_level + Q_LVL_W'(i_push) - Q_LVL_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    assign o_req          = r_mem[r_rd];
    assign o_status.level = r_level;
    assign o_status.empty = (r_level == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !do_pop |-> r_level < Q_LVL_W'(Q_DEPTH))
        else $error("request queue overflow");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= Q_LVL_W'(Q_DEPTH))
        else $error("queue level out of range");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_level != '0)
        else $error("pop from empty queue");

endmodule

>>> design/lbp_back.sv
module lbp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lbp_pkg::RAD_W-1:0]    i_rad,
    input  logic                         i_four,
    input  lbp_pkg::t_q_status           i_q_status,
    input  lbp_pkg::t_req                i_req,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [lbp_pkg::CODE_W-1:0]   o_lbp_code,
    output logic [lbp_pkg::CX_W-1:0]     o_center_x,
    output logic [lbp_pkg::CY_W-1:0]     o_center_y,
    output logic                         o_frame_last
);
    import lbp_pkg::*;

    t_wgt               wgt;
    logic               adv;

    logic               r_b1_valid;
    logic [PROD_W-1:0]  r_b1_oo [4];
    logic [PROD_W-1:0]  r_b1_ii [4];
    logic [PROD_W-1:0]  r_b1_mix [4];
    logic [3:0]         r_b1_ax;
    logic [PIX_W-1:0]   r_b1_center;
    logic [CX_W-1:0]    r_b1_cx;
    logic [CY_W-1:0]    r_b1_cy;
    logic               r_b1_last;

    logic               r_valid;
    logic [CODE_W-1:0]  r_code;
    logic [CX_W-1:0]    r_cx;
    logic [CY_W-1:0]    r_cy;
    logic               r_last;

    logic [3:0]         dg;
    logic [CODE_W-1:0]  n_code;
    logic [PROD_W-1:0]  thr;

    assign wgt   = radius_weights(i_rad);
    assign adv   = ~r_valid | ~i_stall;
    assign o_pop = adv & ~i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else if (adv) begin
            r_b1_valid <= ~i_q_status.empty;
            r_valid    <= r_b1_valid;
        end
    end

    // diagonal products, one lane per diagonal; axis compares
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                r_b1_oo[i]  <= PROD_W'(wgt.w_oo) * PROD_W'(i_req.outer[i]);
                r_b1_ii[i]  <= PROD_W'(wgt.w_ii) * PROD_W'(i_req.inner[i]);
                r_b1_mix[i] <= PROD_W'(wgt.w_mix) * PROD_W'(i_req.mixed[i]);
                r_b1_ax[i]  <= i_req.axis[i] >= i_req.center;
            end
            r_b1_center <= i_req.center;
            r_b1_cx     <= i_req.cx;
            r_b1_cy     <= i_req.cy;
            r_b1_last   <= i_req.last;
        end
    end

    assign thr = PROD_W'({r_b1_center, 16'h0000});

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dg[i] = (r_b1_oo[i] + r_b1_ii[i] + r_b1_mix[i]) >= thr;
        end
        if (i_four) begin
            n_code = {4'b0000, r_b1_ax};
        end else begin
            n_code = {dg[3], r_b1_ax[3], dg[2], r_b1_ax[2],
                      dg[1], r_b1_ax[1], dg[0], r_b1_ax[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_code <= n_code;
            r_cx   <= r_b1_cx;
            r_cy   <= r_b1_cy;
            r_last <= r_b1_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_lbp_code   = r_code;
    assign o_center_x   = r_cx;
    assign o_center_y   = r_cy;
    assign o_frame_last = r_last;

endmodule
